>>> sv/cem_pkg.sv
// Shared types and constants for the compass edge magnitude unit.
// Holds the request and result payload structs, the 3x3 window type and the register map.
// No dependencies; cem_magnitude and the top level refer to it by scoped names.
package cem_pkg;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       frame_start;
    } t_cem_in;

    typedef struct packed {
        logic [7:0]  pixel_out;
        logic        out_valid;
        logic [11:0] out_row;
        logic [11:0] out_col;
    } t_cem_out;

    // Window indexed [row][col]; row 0 is the oldest line, col 2 the newest pixel.
    typedef logic [2:0][2:0][7:0] t_cem_window;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cem_reg;

    localparam int          CFG_AW         = 3;
    localparam int          DIM_W          = 13;
    localparam logic [12:0] DIM_RESET      = 13'd512;
    localparam int          DIM_MIN        = 3;
    localparam int          COORD_W        = 12;
    localparam logic [7:0]  PIX_SAT        = 8'd255;

endpackage

>>> sv/cem_line_mem.sv
// Line buffer memory: one write port, one registered read port.
// A write and a read of the same address in one cycle returns the new data.
// Depends on nothing; instantiated by compass_edge_magnitude_3x3_unit.
module cem_line_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    output logic [DW-1:0]            o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;
    logic [DW-1:0] r_wd;
    logic          r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd  <= r_mem[i_rd_addr];
            r_wd  <= i_wr_data;
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_wd : r_rd;

endmodule

>>> sv/cem_magnitude.sv
// Robinson compass magnitude of one 3x3 window: the largest absolute response
// of the N, NW, W and SW masks, saturated to 8 bits. Uses cem_pkg.
module cem_magnitude (
    input  cem_pkg::t_cem_window i_win,
    output logic [7:0]           o_mag
);

    logic signed [11:0] a, b, c, d, f, g, h, k;
    logic signed [11:0] rn, rnw, rw, rsw;
    logic [10:0]        an, anw, aw, asw;
    logic [10:0]        m0, m1, mx;

    always_comb begin
        a = $signed({4'b0, i_win[0][0]});
        b = $signed({4'b0, i_win[0][1]});
        c = $signed({4'b0, i_win[0][2]});
        d = $signed({4'b0, i_win[1][0]});
        f = $signed({4'b0, i_win[1][2]});
        g = $signed({4'b0, i_win[2][0]});
        h = $signed({4'b0, i_win[2][1]});
        k = $signed({4'b0, i_win[2][2]});

        rn  = c - a + ((f - d) <<< 1) + k - g;
        rnw = b + (c <<< 1) - d + f - (g <<< 1) - h;
        rw  = a + (b <<< 1) + c - g - (h <<< 1) - k;
        rsw = (a <<< 1) + b + d - f - h - (k <<< 1);
    end

    // Every response lies within +/-1020, so 11 bits hold the absolute value.
    assign an  = rn[11]  ? 11'(-rn)  : rn[10:0];
    assign anw = rnw[11] ? 11'(-rnw) : rnw[10:0];
    assign aw  = rw[11]  ? 11'(-rw)  : rw[10:0];
    assign asw = rsw[11] ? 11'(-rsw) : rsw[10:0];

    assign m0 = (anw > an) ? anw : an;
    assign m1 = (asw > aw) ? asw : aw;
    assign mx = (m1 > m0) ? m1 : m0;

    assign o_mag = (mx > 11'(cem_pkg::PIX_SAT)) ? cem_pkg::PIX_SAT : mx[7:0];

endmodule

>>> sv/compass_edge_magnitude_3x3_unit.sv
// Top level of the streaming 3x3 Robinson compass edge magnitude unit.
// Depends on cem_pkg, cem_line_mem and cem_magnitude.
//
//   Port group   Direction  Handshake              Payload
//   in           request    i_in_valid/o_in_ready  i_in_data  (cem_pkg::t_cem_in)
//   out          result     o_out_valid/i_out_ready o_out_data (cem_pkg::t_cem_out)
//   config       APB        psel/penable/pwrite    paddr, pwdata, prdata
//
// One request per clock cycle while the output register is empty or being taken;
// every request yields exactly one result, passing through the registered line buffer
// read, the window register and the output register. All stages advance together when
// the output register is empty or being taken, so a stalled result stops the pipe without losing data.
// Reset clears counters, window and stage valids; the line buffers need no clear.
module compass_edge_magnitude_3x3_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cem_pkg::t_cem_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cem_pkg::t_cem_out               o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cem_pkg::CFG_AW-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Configuration registers.
    logic [cem_pkg::DIM_W-1:0] r_width;
    logic [cem_pkg::DIM_W-1:0] r_height;
    logic                      cfg_wr;
    cem_pkg::t_cem_reg         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = cem_pkg::t_cem_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cem_pkg::DIM_RESET;
            r_height <= cem_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                cem_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[cem_pkg::DIM_W-1:0];
                cem_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[cem_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            cem_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_width);
            cem_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_height);
            default:                   prdata = '0;
        endcase
    end

    // Last column and last row index after clamping to the legal range.
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;

    always_comb begin
        if (32'(r_width) < 32'(cem_pkg::DIM_MIN)) begin
            col_last = CW'(cem_pkg::DIM_MIN - 1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            col_last = CW'(MAX_WIDTH - 1);
        end else begin
            col_last = CW'(32'(r_width) - 32'd1);
        end
        if (32'(r_height) < 32'(cem_pkg::DIM_MIN)) begin
            row_last = RW'(cem_pkg::DIM_MIN - 1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            row_last = RW'(MAX_HEIGHT - 1);
        end else begin
            row_last = RW'(32'(r_height) - 32'd1);
        end
    end

    // Pipeline control.
    logic adv;
    logic accept;

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    // Raster position counters.
    logic [CW-1:0] r_col, n_col, cur_col;
    logic [RW-1:0] r_row, n_row, cur_row;

    always_comb begin
        cur_col = i_in_data.frame_start ? '0 : r_col;
        cur_row = i_in_data.frame_start ? '0 : r_row;
        if (cur_col >= col_last) begin
            n_col = '0;
            n_row = (cur_row >= row_last) ? '0 : RW'(cur_row + 1'b1);
        end else begin
            n_col = CW'(cur_col + 1'b1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: line buffer read in flight.
    logic          r_s1_v;
    logic [7:0]    r_s1_px;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic [15:0]   rd_data;
    logic          mem_wr;

    assign mem_wr = adv && r_s1_v;

    // Upper byte holds the row two above, lower byte the row just above.
    cem_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (16)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[7:0], r_s1_px}),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= i_in_data.pixel_in;
            r_s1_col <= cur_col;
            r_s1_row <= cur_row;
        end
    end

    // Stage 2: window shifted, emission flags known.
    cem_pkg::t_cem_window r_win;
    logic                 r_s2_v;
    logic                 r_s2_emit;
    logic                 r_s2_border;
    logic [CW-1:0]        r_s2_col;
    logic [RW-1:0]        r_s2_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_win  <= '0;
        end else if (adv) begin
            r_s2_v <= r_s1_v;
            if (r_s1_v) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= rd_data[15:8];
                r_win[1][2] <= rd_data[7:0];
                r_win[2][2] <= r_s1_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_v) begin
            r_s2_emit   <= (r_s1_row != '0) && (r_s1_col != '0);
            r_s2_border <= (r_s1_row == RW'(1)) || (r_s1_col == CW'(1));
            r_s2_col    <= CW'(r_s1_col - 1'b1);
            r_s2_row    <= RW'(r_s1_row - 1'b1);
        end
    end

    // Stage 3: output register.
    logic [7:0]        mag;
    cem_pkg::t_cem_out res;
    logic              r_out_valid;
    cem_pkg::t_cem_out r_out_data;

    cem_magnitude u_magnitude (
        .i_win (r_win),
        .o_mag (mag)
    );

    always_comb begin
        res = '0;
        if (r_s2_emit) begin
            res.pixel_out = r_s2_border ? r_win[1][1] : mag;
            res.out_valid = 1'b1;
            res.out_row   = cem_pkg::COORD_W'(r_s2_row);
            res.out_col   = cem_pkg::COORD_W'(r_s2_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_v) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for compass_edge_magnitude_3x3_unit.
// Drives raster pixel requests and predicts each result that is not typed in from its own copy of the window state.
// Depends on cem_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_COLS    = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_CAP  = 40;

    localparam cem_pkg::t_cem_out NO_PIXEL = '0;

    // One row of the directed part: request, whether the result is typed in, typed result.
    typedef struct packed {
        cem_pkg::t_cem_in  item;
        logic              typed;
        cem_pkg::t_cem_out result;
    } t_pixel_case;

    // Width and height are clamped to 3 here, so each frame is 3x3.
    localparam t_pixel_case PIXEL_CASES [28] = '{
        // Bright top row over a dark frame: saturated horizontal edge.
        {8'd255, 1'b1, 1'b1, NO_PIXEL},
        {8'd255, 1'b0, 1'b1, NO_PIXEL},
        {8'd255, 1'b0, 1'b1, NO_PIXEL},
        {8'd0,   1'b0, 1'b1, NO_PIXEL},
        {8'd0,   1'b0, 1'b1, 8'd255, 1'b1, 12'd0, 12'd0},
        {8'd0,   1'b0, 1'b1, 8'd255, 1'b1, 12'd0, 12'd1},
        {8'd0,   1'b0, 1'b1, NO_PIXEL},
        {8'd0,   1'b0, 1'b1, 8'd0,   1'b1, 12'd1, 12'd0},
        {8'd0,   1'b0, 1'b1, 8'd255, 1'b1, 12'd1, 12'd1},
        // The counters wrap into a new frame without a frame start; flat image.
        {8'd128, 1'b0, 1'b1, NO_PIXEL},
        {8'd128, 1'b0, 1'b1, NO_PIXEL},
        {8'd128, 1'b0, 1'b1, NO_PIXEL},
        {8'd128, 1'b0, 1'b1, NO_PIXEL},
        {8'd128, 1'b0, 1'b1, 8'd128, 1'b1, 12'd0, 12'd0},
        {8'd128, 1'b0, 1'b1, 8'd128, 1'b1, 12'd0, 12'd1},
        {8'd128, 1'b0, 1'b1, NO_PIXEL},
        {8'd128, 1'b0, 1'b1, 8'd128, 1'b1, 12'd1, 12'd0},
        {8'd128, 1'b0, 1'b1, 8'd0,   1'b1, 12'd1, 12'd1},
        // A frame start on the second pixel restarts the frame at its origin.
        {8'd7,   1'b0, 1'b1, NO_PIXEL},
        {8'd200, 1'b1, 1'b1, NO_PIXEL},
        {8'd1,   1'b0, 1'b1, NO_PIXEL},
        {8'd254, 1'b0, 1'b1, NO_PIXEL},
        {8'd90,  1'b0, 1'b1, NO_PIXEL},
        {8'd30,  1'b0, 1'b1, 8'd200, 1'b1, 12'd0, 12'd0},
        {8'd0,   1'b0, 1'b0, NO_PIXEL},
        {8'd255, 1'b0, 1'b0, NO_PIXEL},
        {8'd17,  1'b0, 1'b0, NO_PIXEL},
        {8'd240, 1'b0, 1'b0, NO_PIXEL}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    cem_pkg::t_cem_in  i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    cem_pkg::t_cem_out o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [cem_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state.
    logic [7:0]           prev_row_pix  [MAX_COLS];
    logic [7:0]           prev2_row_pix [MAX_COLS];
    cem_pkg::t_cem_window pix_win    = '0;
    int                   row_pos    = 0;
    int                   col_pos    = 0;
    logic [12:0]          width_reg  = cem_pkg::DIM_RESET;
    logic [12:0]          height_reg = cem_pkg::DIM_RESET;

    cem_pkg::t_cem_out    expected_pixels [$];
    int                   mismatches = 0;

    bit          steady     = 1'b0;
    bit          hold_armed = 1'b0;
    bit          hold_done  = 1'b0;
    int          hold_left  = 0;

    compass_edge_magnitude_3x3_unit #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < REPORT_CAP) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int dim_limit(input logic [12:0] v, input int top);
        if (v < cem_pkg::DIM_MIN) return cem_pkg::DIM_MIN;
        if (v > top) return top;
        return v;
    endfunction

    // Largest absolute response of the N, NW, W and SW masks, saturated to 8 bits.
    function automatic logic [7:0] compass_peak(input cem_pkg::t_cem_window w);
        int a, b, c, d, f, g, h, k;
        int resp [4];
        int peak;
        a = w[0][0]; b = w[0][1]; c = w[0][2];
        d = w[1][0];              f = w[1][2];
        g = w[2][0]; h = w[2][1]; k = w[2][2];
        resp[0] = -a + c - 2 * d + 2 * f - g + k;
        resp[1] = b + 2 * c - d + f - 2 * g - h;
        resp[2] = a + 2 * b + c - g - 2 * h - k;
        resp[3] = 2 * a + b + d - f - h - 2 * k;
        peak = 0;
        foreach (resp[n]) begin
            if (resp[n] < 0) resp[n] = -resp[n];
            if (resp[n] > peak) peak = resp[n];
        end
        return (peak > 255) ? cem_pkg::PIX_SAT : 8'(peak);
    endfunction

    // Advances the line buffers, window and counters by one pixel and returns its result.
    function automatic cem_pkg::t_cem_out predict_edge(input cem_pkg::t_cem_in item);
        cem_pkg::t_cem_out res;
        int eff_w, eff_h, r, c, rr;
        logic [7:0] top, mid;
        eff_w = dim_limit(width_reg, MAX_COLS);
        eff_h = dim_limit(height_reg, MAX_ROWS);
        if (item.frame_start) begin
            row_pos = 0;
            col_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        top = prev2_row_pix[c];
        mid = prev_row_pix[c];
        prev2_row_pix[c] = mid;
        prev_row_pix[c] = item.pixel_in;
        for (rr = 0; rr < 3; rr++) begin
            pix_win[rr][0] = pix_win[rr][1];
            pix_win[rr][1] = pix_win[rr][2];
        end
        pix_win[0][2] = top;
        pix_win[1][2] = mid;
        pix_win[2][2] = item.pixel_in;
        res = '0;
        if (r >= 1 && c >= 1) begin
            res.out_valid = 1'b1;
            res.out_row   = 12'(r - 1);
            res.out_col   = 12'(c - 1);
            res.pixel_out = (r == 1 || c == 1) ? pix_win[1][1] : compass_peak(pix_win);
        end
        if (c >= eff_w - 1) begin
            col_pos = 0;
            row_pos = (r >= eff_h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        return res;
    endfunction

    task automatic cfg_access(input cem_pkg::t_cem_reg idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The last request has already been taken, so valid drops before waiting.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [31:0] w, input logic [31:0] h);
        logic [31:0] rd;
        drain();
        cfg_access(cem_pkg::REG_IMAGE_WIDTH, 1'b1, w, rd);
        cfg_access(cem_pkg::REG_IMAGE_HEIGHT, 1'b1, h, rd);
        width_reg  = w[12:0];
        height_reg = h[12:0];
        cfg_access(cem_pkg::REG_IMAGE_WIDTH, 1'b0, '0, rd);
        if (rd != 32'(width_reg)) report_mismatch("image_width readback", rd, width_reg);
        cfg_access(cem_pkg::REG_IMAGE_HEIGHT, 1'b0, '0, rd);
        if (rd != 32'(height_reg)) report_mismatch("image_height readback", rd, height_reg);
    endtask

    task automatic send_pixel(input cem_pkg::t_cem_in item, input logic typed,
                              input cem_pkg::t_cem_out given);
        cem_pkg::t_cem_out predicted;
        if (!steady && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_edge(item);
        expected_pixels.push_back(typed ? given : predicted);
    endtask

    task automatic run_phase(input logic [31:0] w, input logic [31:0] h, input int count,
                             input bit calm, input bit squeeze);
        cem_pkg::t_cem_in item;
        int pick, v;
        logic [7:0] last;
        set_dims(w, h);
        steady = calm;
        if (squeeze) hold_armed = 1'b1;
        last = 8'($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            // Most frames are marked at their origin; a few requests restart a frame early.
            item.frame_start = (n == 0) || (row_pos == 0 && col_pos == 0 && pick >= 20)
                               || (pick < 2);
            case ($urandom_range(0, 7))
                0: item.pixel_in = 8'd0;
                1: item.pixel_in = 8'd255;
                2, 3, 4: begin
                    v = int'(last) + int'($urandom_range(0, 24)) - 12;
                    item.pixel_in = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                end
                default: item.pixel_in = 8'($urandom);
            endcase
            last = item.pixel_in;
            send_pixel(item, 1'b0, NO_PIXEL);
        end
    endtask

    // Result side: random back-pressure unless steady, one long hold-off when asked for.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge i_clk) begin : result_check
        cem_pkg::t_cem_out due, got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                due = expected_pixels.pop_front();
                if (got.out_valid != due.out_valid)
                    report_mismatch("out_valid", got.out_valid, due.out_valid);
                if (got.out_row != due.out_row)
                    report_mismatch("out_row", got.out_row, due.out_row);
                if (got.out_col != due.out_col)
                    report_mismatch("out_col", got.out_col, due.out_col);
                if (got.pixel_out != due.pixel_out)
                    report_mismatch($sformatf("pixel_out at row %0d col %0d",
                                    due.out_row, due.out_col), got.pixel_out, due.pixel_out);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] rd;
        foreach (prev_row_pix[n]) begin
            prev_row_pix[n]  = '0;
            prev2_row_pix[n] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_access(cem_pkg::REG_IMAGE_WIDTH, 1'b0, '0, rd);
        if (rd != 32'(cem_pkg::DIM_RESET))
            report_mismatch("image_width after reset", rd, cem_pkg::DIM_RESET);
        cfg_access(cem_pkg::REG_IMAGE_HEIGHT, 1'b0, '0, rd);
        if (rd != 32'(cem_pkg::DIM_RESET))
            report_mismatch("image_height after reset", rd, cem_pkg::DIM_RESET);

        // Both dimensions below range, so the frame is the smallest one.
        set_dims(32'd0, 32'd2);
        foreach (PIXEL_CASES[n]) begin
            send_pixel(PIXEL_CASES[n].item, PIXEL_CASES[n].typed, PIXEL_CASES[n].result);
        end

        run_phase(32'd5, 32'd4, 200, 1'b0, 1'b0);
        // All-ones write clamps the width to the line buffer depth.
        run_phase(32'hFFFF_FFFF, 32'd3, 260, 1'b0, 1'b0);
        run_phase(32'd3, 32'd4096, 150, 1'b0, 1'b0);
        run_phase(32'd7, 32'd5, 300, 1'b1, 1'b1);
        run_phase(32'd16, 32'd6, 200, 1'b0, 1'b0);
        run_phase(32'd1, 32'd0, 80, 1'b0, 1'b0);
        run_phase(32'd40, 32'd3, 120, 1'b0, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
sv/cem_pkg.sv
sv/cem_line_mem.sv
sv/cem_magnitude.sv
sv/compass_edge_magnitude_3x3_unit.sv
dv/testbench.sv
